[design/rmcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmcc_pkg: shared types and constants
// Field widths, command codes and the controller/datapath interface structs of
// the region mean color and center block.
// ----------------------------------------------------------------------------
package rmcc_pkg;

  localparam int RID_W  = 10;
  localparam int CHAN_W = 8;
  localparam int SUM_W  = 32;
  localparam int QUOT_W = 8;

  localparam int DEF_MAX_REGIONS = 1024;
  localparam int DEF_COORD_BITS  = 12;
  localparam int DEF_COUNT_BITS  = 24;

  localparam logic [1:0] CMD_ACC   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic sweep;
    logic rd_en;
    logic wr_acc;
    logic wr_clr;
    logic div_start;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_acc;
    logic is_read;
    logic is_clr;
    logic empty;
    logic sweep_last;
    logic div_busy;
    logic out_full;
  } dp_sts_t;

endpackage

[design/rmcc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmcc_div: radix-2 mean divider
// Restoring division, one quotient bit per cycle, for a dividend that is known
// to be below 2**QUOT_W times the divisor.
// ----------------------------------------------------------------------------
module rmcc_div
  import rmcc_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SUM_W-1:0]      dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic [QUOT_W-1:0]     quot,
  output logic                  busy
);

  localparam int DW = (COUNT_BITS + QUOT_W > SUM_W) ? COUNT_BITS + QUOT_W : SUM_W;
  localparam int SB = $clog2(QUOT_W);

  logic [SUM_W-1:0]      rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] den_r;
  logic [QUOT_W-1:0]     q_r, q_nxt;
  logic [SB-1:0]         step_r;
  logic                  run_r;
  logic [DW-1:0]         shifted;
  logic [DW-1:0]         rem_ext;

  assign shifted = DW'(den_r) << step_r;
  assign rem_ext = DW'(rem_r);

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    if (rem_ext >= shifted) begin
      rem_nxt        = SUM_W'(rem_ext - shifted);
      q_nxt[step_r]  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
    end else if (run_r && step_r == '0) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      den_r  <= divisor;
      q_r    <= '0;
      step_r <= SB'(QUOT_W - 1);
    end else if (run_r) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      step_r <= step_r - 1'b1;
    end
  end

  assign quot = q_r;
  assign busy = run_r;

endmodule

[design/rmcc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmcc_dp: statistics datapath
// Request capture, region statistics memory with read-modify-write update,
// three channel dividers, center arithmetic and the result register.
// ----------------------------------------------------------------------------
module rmcc_dp
  import rmcc_pkg::*;
#(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int COORD_BITS  = DEF_COORD_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              ctl,
  output dp_sts_t               sts,
  input  logic [1:0]            in_cmd,
  input  logic [RID_W-1:0]      in_region_id,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  input  logic [CHAN_W-1:0]     in_chan_a,
  input  logic [CHAN_W-1:0]     in_chan_b,
  input  logic [CHAN_W-1:0]     in_chan_c,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RID_W-1:0]      out_region,
  output logic [QUOT_W-1:0]     out_mean_a,
  output logic [QUOT_W-1:0]     out_mean_b,
  output logic [QUOT_W-1:0]     out_mean_c,
  output logic [COORD_BITS-1:0] out_center_x,
  output logic [COORD_BITS-1:0] out_center_y,
  output logic                  out_is_empty
);

  localparam int AW  = $clog2(MAX_REGIONS);
  localparam int SW1 = SUM_W + 1;

  typedef struct packed {
    logic [SUM_W-1:0]      sum_a;
    logic [SUM_W-1:0]      sum_b;
    logic [SUM_W-1:0]      sum_c;
    logic [COUNT_BITS-1:0] count;
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_y;
  } entry_t;

  // Captured request.
  logic [1:0]            cmd_r;
  logic [RID_W-1:0]      rid_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic [CHAN_W-1:0]     a_r, b_r, c_r;

  entry_t                mem [MAX_REGIONS];
  entry_t                rdata_r;
  entry_t                clr_entry, acc_entry, mem_wdata;
  logic [AW-1:0]         addr, mem_addr;
  logic [AW-1:0]         sweep_cnt_r;
  logic                  region_ok, ovf, mem_we;
  logic [SW1-1:0]        sa, sb, sc;

  logic [QUOT_W-1:0]     qa, qb, qc;
  logic                  busy_a, busy_b, busy_c;
  logic [COORD_BITS-1:0] cx, cy;

  logic                  out_valid_r;
  logic [RID_W-1:0]      out_region_r;
  logic [QUOT_W-1:0]     mean_a_r, mean_b_r, mean_c_r;
  logic [COORD_BITS-1:0] center_x_r, center_y_r;
  logic                  is_empty_r;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_cmd;
      rid_r <= in_region_id;
      x_r   <= in_pixel_x;
      y_r   <= in_pixel_y;
      a_r   <= in_chan_a;
      b_r   <= in_chan_b;
      c_r   <= in_chan_c;
    end
  end

  assign addr      = AW'(rid_r);
  assign region_ok = 32'(rid_r) < 32'(MAX_REGIONS);

  always_comb begin
    clr_entry       = '0;
    clr_entry.min_x = '1;
    clr_entry.min_y = '1;
  end

  // An accumulate that would overflow the count or any sum is dropped whole.
  assign sa  = SW1'(rdata_r.sum_a) + SW1'(a_r);
  assign sb  = SW1'(rdata_r.sum_b) + SW1'(b_r);
  assign sc  = SW1'(rdata_r.sum_c) + SW1'(c_r);
  assign ovf = sa[SUM_W] | sb[SUM_W] | sc[SUM_W] | (rdata_r.count == '1);

  always_comb begin
    acc_entry.sum_a = sa[SUM_W-1:0];
    acc_entry.sum_b = sb[SUM_W-1:0];
    acc_entry.sum_c = sc[SUM_W-1:0];
    acc_entry.count = rdata_r.count + 1'b1;
    acc_entry.min_x = (x_r < rdata_r.min_x) ? x_r : rdata_r.min_x;
    acc_entry.max_x = (x_r > rdata_r.max_x) ? x_r : rdata_r.max_x;
    acc_entry.min_y = (y_r < rdata_r.min_y) ? y_r : rdata_r.min_y;
    acc_entry.max_y = (y_r > rdata_r.max_y) ? y_r : rdata_r.max_y;
  end

  assign mem_we    = ctl.sweep | (ctl.wr_clr & region_ok) | (ctl.wr_acc & region_ok & ~ovf);
  assign mem_addr  = ctl.sweep ? sweep_cnt_r : addr;
  assign mem_wdata = ctl.wr_acc ? acc_entry : clr_entry;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (ctl.sweep) begin
      sweep_cnt_r <= sweep_cnt_r + 1'b1;
    end
  end

  rmcc_div #(.COUNT_BITS(COUNT_BITS)) u_div_a (
    .clk(clk), .rst_n(rst_n), .start(ctl.div_start), .dividend(rdata_r.sum_a),
    .divisor(rdata_r.count), .quot(qa), .busy(busy_a)
  );
  rmcc_div #(.COUNT_BITS(COUNT_BITS)) u_div_b (
    .clk(clk), .rst_n(rst_n), .start(ctl.div_start), .dividend(rdata_r.sum_b),
    .divisor(rdata_r.count), .quot(qb), .busy(busy_b)
  );
  rmcc_div #(.COUNT_BITS(COUNT_BITS)) u_div_c (
    .clk(clk), .rst_n(rst_n), .start(ctl.div_start), .dividend(rdata_r.sum_c),
    .divisor(rdata_r.count), .quot(qc), .busy(busy_c)
  );

  // A non-empty region always has min <= max, so the span never wraps.
  assign cx = rdata_r.min_x + ((rdata_r.max_x - rdata_r.min_x) >> 1);
  assign cy = rdata_r.min_y + ((rdata_r.max_y - rdata_r.min_y) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_region_r <= rid_r;
      is_empty_r   <= sts.empty;
      if (sts.empty) begin
        mean_a_r   <= '0;
        mean_b_r   <= '0;
        mean_c_r   <= '0;
        center_x_r <= '0;
        center_y_r <= '0;
      end else begin
        mean_a_r   <= qa;
        mean_b_r   <= qb;
        mean_c_r   <= qc;
        center_x_r <= cx;
        center_y_r <= cy;
      end
    end
  end

  always_comb begin
    sts.is_acc     = (cmd_r == CMD_ACC);
    sts.is_read    = (cmd_r == CMD_READ);
    sts.is_clr     = (cmd_r == CMD_CLEAR);
    sts.empty      = ~region_ok | (rdata_r.count == '0);
    sts.sweep_last = (sweep_cnt_r == AW'(MAX_REGIONS - 1));
    sts.div_busy   = busy_a | busy_b | busy_c;
    sts.out_full   = out_valid_r;
  end

  assign out_valid    = out_valid_r;
  assign out_region   = out_region_r;
  assign out_mean_a   = mean_a_r;
  assign out_mean_b   = mean_b_r;
  assign out_mean_c   = mean_c_r;
  assign out_center_x = center_x_r;
  assign out_center_y = center_y_r;
  assign out_is_empty = is_empty_r;

endmodule

[design/rmcc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmcc_ctrl: request sequencer
// Runs the memory clearing sweep after reset, then steps each request through
// capture, memory read, update or division, and result hand-off.
// ----------------------------------------------------------------------------
module rmcc_ctrl
  import rmcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_sts_t  sts,
  output ctl_cmd_t ctl
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RD    = 6'b000100,
    ST_EX    = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_CLEAR: begin
        ctl.sweep = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_RD;
        end
      end
      ST_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = ST_EX;
      end
      ST_EX: begin
        state_nxt = ST_IDLE;
        if (sts.is_acc) begin
          ctl.wr_acc = 1'b1;
        end else if (sts.is_clr) begin
          ctl.wr_clr = 1'b1;
        end else if (sts.is_read) begin
          if (sts.empty) begin
            state_nxt = ST_OUT;
          end else begin
            ctl.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_full) begin
          ctl.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> !sts.out_full)
    else $error("result loaded over a pending result");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wr_acc || ctl.wr_clr) |-> $past(ctl.rd_en))
    else $error("memory update without a preceding read");

  a_div_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_start |-> (!sts.empty && sts.is_read))
    else $error("division started for an empty region");

  a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> (state_r == ST_DIV))
    else $error("divider running outside the division state");

endmodule

[design/region_mean_color_and_center.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_mean_color_and_center: per-region color mean and box center engine
// Keeps channel sums, pixel count and bounding box for every region label.
//
// Input channel (in_*): accumulate adds a pixel to its region, clear returns
// one region to empty, read produces one result on the out_* channel.
// Accumulate and clear step through capture, memory read and write back,
// the read-modify-write of the region statistics memory.
// A read of a non-empty region steps through memory read, divider start,
// division, a state that sees the dividers finish, and result load, which
// raises out_valid, and the next request can be taken in the same cycle.
// A read of an empty region skips the dividers and goes from memory read
// straight to result load. After reset a sweep clears all MAX_REGIONS
// entries (1024 by default), during which in_stall stays high.
// Results sit in an output register; while out_stall is high the result holds
// and the next request is still taken, but a second read result waits in
// the sequencer, stalling the input, until the register frees.
// ----------------------------------------------------------------------------
module region_mean_color_and_center
  import rmcc_pkg::*;
#(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int COORD_BITS  = DEF_COORD_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_cmd,
  input  logic [RID_W-1:0]      in_region_id,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  input  logic [CHAN_W-1:0]     in_chan_a,
  input  logic [CHAN_W-1:0]     in_chan_b,
  input  logic [CHAN_W-1:0]     in_chan_c,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RID_W-1:0]      out_region,
  output logic [QUOT_W-1:0]     out_mean_a,
  output logic [QUOT_W-1:0]     out_mean_b,
  output logic [QUOT_W-1:0]     out_mean_c,
  output logic [COORD_BITS-1:0] out_center_x,
  output logic [COORD_BITS-1:0] out_center_y,
  output logic                  out_is_empty
);

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  rmcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  rmcc_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .COORD_BITS  (COORD_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sts          (sts),
    .in_cmd       (in_cmd),
    .in_region_id (in_region_id),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .in_chan_a    (in_chan_a),
    .in_chan_b    (in_chan_b),
    .in_chan_c    (in_chan_c),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_region   (out_region),
    .out_mean_a   (out_mean_a),
    .out_mean_b   (out_mean_b),
    .out_mean_c   (out_mean_c),
    .out_center_x (out_center_x),
    .out_center_y (out_center_y),
    .out_is_empty (out_is_empty)
  );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: region mean color and center
// Sends accumulate, read, clear and unused commands, first a directed set of
// corner cases and then random requests grouped on a few busy regions. Both
// channels idle in random bursts. A tracker keeps every region's sums, pixel
// count and bounding box and checks each read result against its prediction.
// ----------------------------------------------------------------------------
module testbench
  import rmcc_pkg::*;
();

  localparam int N_REGIONS = DEF_MAX_REGIONS;
  localparam int COORD_W   = DEF_COORD_BITS;
  localparam int COUNT_W   = DEF_COUNT_BITS;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_REQS = 420;
  localparam int CALM_REQS   = 80;
  localparam int HOT_N       = 6;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [RID_W-1:0]   region;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  a;
    logic [CHAN_W-1:0]  b;
    logic [CHAN_W-1:0]  c;
  } pixel_req_t;

  typedef struct packed {
    logic [RID_W-1:0]   region;
    logic [QUOT_W-1:0]  mean_a;
    logic [QUOT_W-1:0]  mean_b;
    logic [QUOT_W-1:0]  mean_c;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic               is_empty;
  } region_stats_t;

  class region_stats_tracker;
    bit [SUM_W-1:0]   sum_a [N_REGIONS];
    bit [SUM_W-1:0]   sum_b [N_REGIONS];
    bit [SUM_W-1:0]   sum_c [N_REGIONS];
    bit [COUNT_W-1:0] pix_count [N_REGIONS];
    bit [COORD_W-1:0] min_x [N_REGIONS];
    bit [COORD_W-1:0] max_x [N_REGIONS];
    bit [COORD_W-1:0] min_y [N_REGIONS];
    bit [COORD_W-1:0] max_y [N_REGIONS];
    region_stats_t    pending_stats [$];
    int               bad_results;

    function new();
      bad_results = 0;
      for (int r = 0; r < N_REGIONS; r++) clear_region(r);
    endfunction

    function void clear_region(int r);
      sum_a[r]     = '0;
      sum_b[r]     = '0;
      sum_c[r]     = '0;
      pix_count[r] = '0;
      min_x[r]     = '1;
      max_x[r]     = '0;
      min_y[r]     = '1;
      max_y[r]     = '0;
    endfunction

    function int pending();
      return pending_stats.size();
    endfunction

    function void apply_request(pixel_req_t q);
      bit [SUM_W:0]   na;
      bit [SUM_W:0]   nb;
      bit [SUM_W:0]   nc;
      bit [COUNT_W:0] nn;
      region_stats_t  s;
      int             r;
      r = q.region;
      case (q.cmd)
        CMD_ACC: begin
          if (r < N_REGIONS) begin
            na = sum_a[r] + q.a;
            nb = sum_b[r] + q.b;
            nc = sum_c[r] + q.c;
            nn = pix_count[r] + 1'b1;
            // A pixel that would overflow the count or any sum is dropped whole.
            if (!nn[COUNT_W] && !na[SUM_W] && !nb[SUM_W] && !nc[SUM_W]) begin
              sum_a[r]     = na[SUM_W-1:0];
              sum_b[r]     = nb[SUM_W-1:0];
              sum_c[r]     = nc[SUM_W-1:0];
              pix_count[r] = nn[COUNT_W-1:0];
              if (q.x < min_x[r]) min_x[r] = q.x;
              if (q.x > max_x[r]) max_x[r] = q.x;
              if (q.y < min_y[r]) min_y[r] = q.y;
              if (q.y > max_y[r]) max_y[r] = q.y;
            end
          end
        end
        CMD_CLEAR: begin
          if (r < N_REGIONS) clear_region(r);
        end
        CMD_READ: begin
          s = '0;
          s.region = q.region;
          if (r >= N_REGIONS || pix_count[r] == 0) begin
            s.is_empty = 1'b1;
          end else begin
            s.mean_a   = QUOT_W'(sum_a[r] / pix_count[r]);
            s.mean_b   = QUOT_W'(sum_b[r] / pix_count[r]);
            s.mean_c   = QUOT_W'(sum_c[r] / pix_count[r]);
            s.center_x = min_x[r] + (max_x[r] - min_x[r]) / 2;
            s.center_y = min_y[r] + (max_y[r] - min_y[r]) / 2;
          end
          pending_stats = {pending_stats, s};
        end
        default: ;
      endcase
    endfunction

    function void check_stats(region_stats_t got);
      region_stats_t want;
      if (pending_stats.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("ERROR: unexpected result for region %0d", got.region);
        return;
      end
      want = pending_stats.pop_front();
      if (got !== want) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS) begin
          $display("ERROR: expected region %0d mean %0d/%0d/%0d center %0d,%0d empty %0b",
                   want.region, want.mean_a, want.mean_b, want.mean_c,
                   want.center_x, want.center_y, want.is_empty);
          $display("       actual   region %0d mean %0d/%0d/%0d center %0d,%0d empty %0b",
                   got.region, got.mean_a, got.mean_b, got.mean_c,
                   got.center_x, got.center_y, got.is_empty);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_cmd;
  logic [RID_W-1:0]   in_region_id;
  logic [COORD_W-1:0] in_pixel_x;
  logic [COORD_W-1:0] in_pixel_y;
  logic [CHAN_W-1:0]  in_chan_a;
  logic [CHAN_W-1:0]  in_chan_b;
  logic [CHAN_W-1:0]  in_chan_c;
  logic               out_valid;
  logic               out_stall;
  logic [RID_W-1:0]   out_region;
  logic [QUOT_W-1:0]  out_mean_a;
  logic [QUOT_W-1:0]  out_mean_b;
  logic [QUOT_W-1:0]  out_mean_c;
  logic [COORD_W-1:0] out_center_x;
  logic [COORD_W-1:0] out_center_y;
  logic               out_is_empty;

  region_stats_tracker tracker;
  int sender_gap_pct;
  int sink_stall_pct;
  int hot_regions [HOT_N];
  int hot_base_x [HOT_N];
  int hot_base_y [HOT_N];

  region_mean_color_and_center DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_region_id (in_region_id),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .in_chan_a    (in_chan_a),
    .in_chan_b    (in_chan_b),
    .in_chan_c    (in_chan_c),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_region   (out_region),
    .out_mean_a   (out_mean_a),
    .out_mean_b   (out_mean_b),
    .out_mean_c   (out_mean_c),
    .out_center_x (out_center_x),
    .out_center_y (out_center_y),
    .out_is_empty (out_is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pixel_req_t make_req(logic [1:0] cmd, int region, int x, int y,
                                          int a, int b, int c);
    pixel_req_t q;
    q.cmd    = cmd;
    q.region = RID_W'(region);
    q.x      = COORD_W'(x);
    q.y      = COORD_W'(y);
    q.a      = CHAN_W'(a);
    q.b      = CHAN_W'(b);
    q.c      = CHAN_W'(c);
    return q;
  endfunction

  // Channel values lean toward the two extremes a quarter of the time.
  function automatic int rand_chan();
    case ($urandom_range(7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic pixel_req_t random_req();
    int         pick;
    int         h;
    int         rid;
    int         x;
    int         y;
    logic [1:0] cmd;
    h = $urandom_range(HOT_N - 1);
    rid = ($urandom_range(99) < 90) ? hot_regions[h] : $urandom_range(N_REGIONS - 1);
    pick = $urandom_range(99);
    if (pick < 72) cmd = CMD_ACC;
    else if (pick < 94) cmd = CMD_READ;
    else cmd = CMD_CLEAR;
    // Pixels mostly cluster near a per-region corner so boxes stay varied.
    if ($urandom_range(99) < 70) begin
      x = (hot_base_x[h] + $urandom_range(63)) % (1 << COORD_W);
      y = (hot_base_y[h] + $urandom_range(63)) % (1 << COORD_W);
    end else begin
      x = $urandom_range((1 << COORD_W) - 1);
      y = $urandom_range((1 << COORD_W) - 1);
    end
    return make_req(cmd, rid, x, y, rand_chan(), rand_chan(), rand_chan());
  endfunction

  task automatic hold_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_req(input pixel_req_t q);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_cmd       <= q.cmd;
    in_region_id <= q.region;
    in_pixel_x   <= q.x;
    in_pixel_y   <= q.y;
    in_chan_a    <= q.a;
    in_chan_b    <= q.b;
    in_chan_c    <= q.c;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct)
      hold_input($urandom_range(19, 1));
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0)
      tracker.apply_request(make_req(in_cmd, in_region_id, in_pixel_x, in_pixel_y,
                                     in_chan_a, in_chan_b, in_chan_c));
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_stats(region_stats_t'({out_region, out_mean_a, out_mean_b, out_mean_c,
                                           out_center_x, out_center_y, out_is_empty}));
  end

  // Result side: random stall bursts while sink_stall_pct is nonzero.
  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (burst > 0) burst--;
      else if (sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct)
        burst = $urandom_range(19, 1);
      out_stall <= (burst > 0);
    end
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    tracker        = new();
    sender_gap_pct = 20;
    sink_stall_pct = 20;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_ACC;
    in_region_id   = '0;
    in_pixel_x     = '0;
    in_pixel_y     = '0;
    in_chan_a      = '0;
    in_chan_b      = '0;
    in_chan_c      = '0;
    hot_regions[0] = 0;
    hot_regions[1] = N_REGIONS - 1;
    for (int h = 0; h < HOT_N; h++) begin
      if (h > 1) hot_regions[h] = $urandom_range(N_REGIONS - 1);
      hot_base_x[h] = $urandom_range((1 << COORD_W) - 1);
      hot_base_y[h] = $urandom_range((1 << COORD_W) - 1);
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed corner cases: empty reads, extreme coordinates and channels,
    // single-pixel boxes, the unused command, and clear followed by reuse.
    send_req(make_req(CMD_READ, 0, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_READ, N_REGIONS - 1, 4095, 4095, 255, 255, 255));
    send_req(make_req(CMD_ACC, 0, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_READ, 0, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_ACC, 0, 4095, 4095, 255, 255, 255));
    send_req(make_req(CMD_READ, 0, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_ACC, N_REGIONS - 1, 4095, 0, 255, 0, 128));
    send_req(make_req(CMD_READ, N_REGIONS - 1, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_ACC, N_REGIONS - 1, 1, 4094, 0, 255, 127));
    send_req(make_req(CMD_READ, N_REGIONS - 1, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_UNUSED, N_REGIONS - 1, 2048, 2048, 255, 255, 255));
    send_req(make_req(CMD_READ, N_REGIONS - 1, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_CLEAR, 0, 4095, 4095, 255, 255, 255));
    send_req(make_req(CMD_READ, 0, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_CLEAR, N_REGIONS - 1, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_READ, N_REGIONS - 1, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_ACC, 0, 2730, 1365, 170, 85, 170));
    send_req(make_req(CMD_READ, 0, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_ACC, 'h2AA, 1365, 2730, 85, 170, 85));
    send_req(make_req(CMD_ACC, 'h2AA, 2730, 1365, 170, 85, 170));
    send_req(make_req(CMD_READ, 'h2AA, 0, 0, 0, 0, 0));
    send_req(make_req(CMD_READ, 'h155, 0, 0, 0, 0, 0));

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == 200) begin
        // Let the block drain completely before going on.
        hold_input(1);
        while (tracker.pending() != 0) @(negedge clk);
      end
      if (n == 280) begin
        sender_gap_pct = 0;
        sink_stall_pct = 0;
      end
      if (n == 310) begin
        sender_gap_pct = 20;
        sink_stall_pct = 20;
      end
      if (n == RANDOM_REQS - CALM_REQS) begin
        sender_gap_pct = 0;
        sink_stall_pct = 0;
      end
      if ($urandom_range(99) < 3)
        send_req(make_req(CMD_UNUSED, $urandom_range(N_REGIONS - 1),
                          $urandom_range(4095), $urandom_range(4095),
                          rand_chan(), rand_chan(), rand_chan()));
      send_req(random_req());
    end

    hold_input(1);
    while (tracker.pending() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (tracker.bad_results == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
